### sv/bps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants of the buzzer pattern sequencer
// Command and result beat layouts, mode and event codes, step store entry.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned MAX_STEPS = 16;
  localparam int unsigned STORE_AW  = $clog2(MAX_STEPS);
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned S_DATA_W  = 48;
  localparam int unsigned M_DATA_W  = 24;

  localparam logic [LEN_W-1:0]  MAX_STEPS_L     = LEN_W'(MAX_STEPS);
  localparam logic [FREQ_W-1:0] DEFAULT_FREQ_HZ = 16'd2000;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 3'd0,
    MODE_ON     = 3'd1,
    MODE_OFF    = 3'd2,
    MODE_TOGGLE = 3'd3,
    MODE_BEEP   = 3'd4,
    MODE_TONE   = 3'd5,
    MODE_PLAY   = 3'd6,
    MODE_LOAD   = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_STOP  = 2'd2
  } tone_ev_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PASSIVE_MODE  = 2'd0,
    CFG_TONE_BACKEND  = 2'd1,
    CFG_ON_LEVEL      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic passive_mode;
    logic tone_backend_present;
    logic on_level;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    logic [IDX_W-1:0]   step_index;
    logic               step_on;
    logic [FREQ_W-1:0]  tone_hz;
    logic [DUR_W-1:0]   length_ms;
    logic [LEN_W-1:0]   pattern_length;
    logic               repeat_enable;
  } cmd_t;

  typedef struct packed {
    logic               pin_level;
    tone_ev_e           tone_event;
    logic               tone_running;
    logic [FREQ_W-1:0]  tone_freq_hz;
    logic               pattern_active;
    logic               beep_active;
  } res_t;

  typedef struct packed {
    logic               on;
    logic [FREQ_W-1:0]  freq;
    logic [DUR_W-1:0]   dur;
  } step_t;

  // wrap-safe deadline check: now is at or past the end mark
  function automatic logic reached(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] end_ms);
    logic [TIME_W-1:0] diff;
    diff = now - end_ms;
    return ~diff[TIME_W-1];
  endfunction

endpackage

### sv/buzzer_pattern_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_unit: buzzer controller with pattern playback
// Commands and millisecond ticks in, one status beat out per command.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         command: tuser mode, tdata step/tone/pattern fields
//  m_axis    out        status: pin level, tone event, tone and pattern state
//  cfg       in         register write: passive, tone backend, polarity
//
//  one command per cycle while status beats are taken; each command's status beat
//  passes through the input register, update logic and result register
//  reset clears all control state; the step store is not cleared
//  a stalled result beat holds the command in the input register, so tready
//  drops only when both registers are full
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tuser: mode[2:0]
  // tdata: step_index[3:0], step_on[4], tone_hz[20:5], length_ms[36:21],
  //        pattern_length[41:37], repeat_enable[42], zero[47:43]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bps_pkg::S_DATA_W-1:0]   s_axis_tdata,
  input  logic [bps_pkg::MODE_W-1:0]     s_axis_tuser,
  // tdata: pin_level[0], tone_event[2:1], tone_running[3], tone_freq_hz[19:4],
  //        pattern_active[20], beep_active[21], zero[23:22]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bps_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic                           cfg_data_i
);
  import bps_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  res_t res;
  logic cmd_valid;
  logic out_space;
  logic fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{passive_mode: 1'b0, tone_backend_present: 1'b0, on_level: 1'b1};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PASSIVE_MODE: cfg_q.passive_mode         <= cfg_data_i;
        CFG_TONE_BACKEND: cfg_q.tone_backend_present <= cfg_data_i;
        CFG_ON_LEVEL:     cfg_q.on_level             <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign fire = cmd_valid & out_space;

  bps_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (fire),
    .valid_o       (cmd_valid),
    .cmd_o         (cmd)
  );

  bps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (fire),
    .cmd_i  (cmd),
    .res_o  (res)
  );

  bps_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire),
    .res_i         (res),
    .space_o       (out_space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### sv/bps_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_in_stage: command input register
// Holds one command beat; refills in the cycle the held beat is consumed.
// ----------------------------------------------------------------------------
module bps_in_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bps_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  logic [bps_pkg::MODE_W-1:0]    s_axis_tuser,
  input  logic                          take_i,
  output logic                          valid_o,
  output bps_pkg::cmd_t                 cmd_o
);
  import bps_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q;

  assign s_axis_tready = ~valid_q | take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q.mode           <= mode_e'(s_axis_tuser);
      cmd_q.step_index     <= s_axis_tdata[3:0];
      cmd_q.step_on        <= s_axis_tdata[4];
      cmd_q.tone_hz        <= s_axis_tdata[20:5];
      cmd_q.length_ms      <= s_axis_tdata[36:21];
      cmd_q.pattern_length <= s_axis_tdata[41:37];
      cmd_q.repeat_enable  <= s_axis_tdata[42];
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

### sv/bps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_core: buzzer state, step store and per-command update
// One command is applied per fire; the result reflects the updated state.
// ----------------------------------------------------------------------------
module bps_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bps_pkg::cfg_t   cfg_i,
  input  logic            fire_i,
  input  bps_pkg::cmd_t   cmd_i,
  output bps_pkg::res_t   res_o
);
  import bps_pkg::*;

  logic [TIME_W-1:0] time_q, time_d;
  logic              sounding_q, sounding_d;
  logic              pin_on_q, pin_on_d;
  logic              tone_on_q, tone_on_d;
  logic              beep_q, beep_d;
  logic [TIME_W-1:0] beep_end_q, beep_end_d;
  logic              playing_q, playing_d;
  logic [LEN_W-1:0]  play_index_q, play_index_d;
  logic [LEN_W-1:0]  play_length_q, play_length_d;
  logic              play_repeat_q, play_repeat_d;
  logic [TIME_W-1:0] step_end_q, step_end_d;
  logic [FREQ_W-1:0] freq_q, freq_d;

  step_t store_q [MAX_STEPS];

  logic              tone_mode;
  logic [LEN_W-1:0]  idx_inc;
  logic              past_end;
  logic [LEN_W-1:0]  rd_idx;
  step_t             rd_step;
  logic              load_step;
  logic              do_drive;
  tone_ev_e          ev;

  assign tone_mode = cfg_i.passive_mode & cfg_i.tone_backend_present;
  assign idx_inc   = play_index_q + LEN_W'(1);
  assign past_end  = (idx_inc >= play_length_q);

  // the single store read: step 0 on play or on a wrap, otherwise the next step of a tick
  always_comb begin
    rd_idx = '0;
    if (cmd_i.mode != MODE_PLAY && !past_end) begin
      rd_idx = idx_inc;
    end
  end
  assign rd_step = store_q[rd_idx[STORE_AW-1:0]];

  always_comb begin
    time_d        = time_q;
    sounding_d    = sounding_q;
    pin_on_d      = pin_on_q;
    tone_on_d     = tone_on_q;
    beep_d        = beep_q;
    beep_end_d    = beep_end_q;
    playing_d     = playing_q;
    play_index_d  = play_index_q;
    play_length_d = play_length_q;
    play_repeat_d = play_repeat_q;
    step_end_d    = step_end_q;
    freq_d        = freq_q;
    load_step     = 1'b0;
    do_drive      = 1'b0;
    ev            = EV_NONE;

    unique case (cmd_i.mode)
      MODE_TICK: begin
        time_d = time_q + TIME_W'(1);
        if (playing_q && reached(time_d, step_end_q)) begin
          play_index_d = idx_inc;
          if (past_end && !play_repeat_q) begin
            // pattern over: buzzer off, any beep cancelled
            beep_d     = 1'b0;
            playing_d  = 1'b0;
            sounding_d = 1'b0;
            do_drive   = 1'b1;
          end else begin
            if (past_end) begin
              play_index_d = '0;
            end
            load_step = 1'b1;
          end
        end
        if (load_step) begin
          freq_d     = (rd_step.freq == '0) ? DEFAULT_FREQ_HZ : rd_step.freq;
          sounding_d = rd_step.on;
          do_drive   = 1'b1;
          step_end_d = time_d + TIME_W'(rd_step.dur);
        end
        if (beep_d && reached(time_d, beep_end_q)) begin
          beep_d     = 1'b0;
          sounding_d = 1'b0;
          do_drive   = 1'b1;
        end
      end
      MODE_ON, MODE_OFF, MODE_TOGGLE, MODE_TONE: begin
        beep_d    = 1'b0;
        playing_d = 1'b0;
        do_drive  = 1'b1;
        if (cmd_i.mode == MODE_OFF) begin
          sounding_d = 1'b0;
        end else if (cmd_i.mode == MODE_TOGGLE) begin
          sounding_d = ~sounding_q;
        end else begin
          sounding_d = 1'b1;
        end
        if (cmd_i.mode == MODE_TONE) begin
          freq_d = (cmd_i.tone_hz == '0) ? DEFAULT_FREQ_HZ : cmd_i.tone_hz;
        end
      end
      MODE_BEEP: begin
        playing_d  = 1'b0;
        sounding_d = 1'b1;
        do_drive   = 1'b1;
        beep_d     = 1'b1;
        beep_end_d = time_q + TIME_W'(cmd_i.length_ms);
      end
      MODE_PLAY: begin
        if (cmd_i.pattern_length != '0) begin
          play_length_d = (cmd_i.pattern_length > MAX_STEPS_L) ? MAX_STEPS_L
                                                               : cmd_i.pattern_length;
          play_index_d  = '0;
          play_repeat_d = cmd_i.repeat_enable;
          playing_d     = 1'b1;
          beep_d        = 1'b0;
          freq_d        = (rd_step.freq == '0) ? DEFAULT_FREQ_HZ : rd_step.freq;
          sounding_d    = rd_step.on;
          do_drive      = 1'b1;
          step_end_d    = time_q + TIME_W'(rd_step.dur);
        end
      end
      MODE_LOAD: begin
        // store write is done in its own clocked block
      end
      default: begin
      end
    endcase

    // every change of sounding is followed by a drive, so drive once with the final value
    if (do_drive) begin
      if (tone_mode) begin
        tone_on_d = sounding_d;
        ev        = sounding_d ? EV_START : EV_STOP;
      end else begin
        pin_on_d  = sounding_d;
      end
    end

    res_o.pin_level      = pin_on_d ? cfg_i.on_level : ~cfg_i.on_level;
    res_o.tone_event     = ev;
    res_o.tone_running   = tone_on_d;
    res_o.tone_freq_hz   = freq_d;
    res_o.pattern_active = playing_d;
    res_o.beep_active    = beep_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q        <= '0;
      sounding_q    <= 1'b0;
      pin_on_q      <= 1'b0;
      tone_on_q     <= 1'b0;
      beep_q        <= 1'b0;
      beep_end_q    <= '0;
      playing_q     <= 1'b0;
      play_index_q  <= '0;
      play_length_q <= '0;
      play_repeat_q <= 1'b0;
      step_end_q    <= '0;
      freq_q        <= DEFAULT_FREQ_HZ;
    end else if (fire_i) begin
      time_q        <= time_d;
      sounding_q    <= sounding_d;
      pin_on_q      <= pin_on_d;
      tone_on_q     <= tone_on_d;
      beep_q        <= beep_d;
      beep_end_q    <= beep_end_d;
      playing_q     <= playing_d;
      play_index_q  <= play_index_d;
      play_length_q <= play_length_d;
      play_repeat_q <= play_repeat_d;
      step_end_q    <= step_end_d;
      freq_q        <= freq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && cmd_i.mode == MODE_LOAD && {1'b0, cmd_i.step_index} < MAX_STEPS_L) begin
      store_q[cmd_i.step_index[STORE_AW-1:0]] <= '{on:   cmd_i.step_on,
                                                   freq: cmd_i.tone_hz,
                                                   dur:  cmd_i.length_ms};
    end
  end

  // a beep and a pattern never run together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(beep_q && playing_q))
    else $error("beep and pattern active at once");

  // while playing, the step index stays inside the loaded length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   playing_q |-> (play_index_q < play_length_q) &&
                                 (play_length_q <= MAX_STEPS_L))
    else $error("pattern step index out of range");

  // tone generator state only moves on a command taken in tone mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (tone_on_q != $past(tone_on_q)) |-> $past(fire_i && tone_mode))
    else $error("tone state changed outside tone mode");

  // the pin drive state only moves on a command taken in pin mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pin_on_q != $past(pin_on_q)) |-> $past(fire_i && !tone_mode))
    else $error("pin state changed in tone mode");

endmodule

### sv/bps_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_out_stage: result register
// Holds one result beat until the sink takes it; reloads in the same cycle.
// ----------------------------------------------------------------------------
module bps_out_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  bps_pkg::res_t                 res_i,
  output logic                          space_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bps_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import bps_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign space_o = ~valid_q | m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (space_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {2'b00,
                          res_q.beep_active,
                          res_q.pattern_active,
                          res_q.tone_freq_hz,
                          res_q.tone_running,
                          res_q.tone_event,
                          res_q.pin_level};

endmodule

### tb/sv/tb_buzzer_pattern_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buzzer_pattern_sequencer_unit: self-checking bench for the buzzer sequencer
// Sends commands and millisecond ticks on the command stream, predicts every
// status beat with an untimed model of the sequencer and compares it field by
// field, across all register settings, with random idling on both streams,
// a long receiver hold-off and sender pauses.
// ----------------------------------------------------------------------------
module tb_buzzer_pattern_sequencer_unit;
  import bps_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int MAX_REPORTS  = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [MODE_W-1:0]    s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic                 cfg_data_i    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  buzzer_pattern_sequencer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // sequencer model state
  cfg_t              cfg_m;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] beep_due;
  logic [TIME_W-1:0] step_due;
  logic              buzz_on;
  logic              pin_on;
  logic              tone_live;
  logic              beep_armed;
  logic              pat_run;
  logic              pat_loop;
  logic [LEN_W-1:0]  pat_pos;
  logic [LEN_W-1:0]  pat_len;
  logic [FREQ_W-1:0] freq_now;
  step_t             step_tab [MAX_STEPS];
  logic [MAX_STEPS-1:0] step_loaded;
  tone_ev_e          ev_now;

  res_t status_q[$];

  int n_cmds;
  int n_status;
  int n_errors;
  int n_starts;
  int n_stops;
  int n_wraps;
  int n_settings;
  int mode_seen [8];

  bit src_jitter;
  bit sink_jitter;
  int hold_left;
  int stall_left;
  int quiet_cycles;

  function automatic void reset_model();
    cfg_m       = '{passive_mode: 1'b0, tone_backend_present: 1'b0, on_level: 1'b1};
    now_ms      = '0;
    beep_due    = '0;
    step_due    = '0;
    buzz_on     = 1'b0;
    pin_on      = 1'b0;
    tone_live   = 1'b0;
    beep_armed  = 1'b0;
    pat_run     = 1'b0;
    pat_loop    = 1'b0;
    pat_pos     = '0;
    pat_len     = '0;
    freq_now    = DEFAULT_FREQ_HZ;
    step_loaded = '0;
  endfunction

  // signed difference keeps the compare correct across counter wrap
  function automatic logic deadline_hit(input logic [TIME_W-1:0] mark);
    logic [TIME_W-1:0] diff;
    diff = now_ms - mark;
    return !diff[TIME_W-1];
  endfunction

  function automatic void sound_out();
    if (cfg_m.passive_mode && cfg_m.tone_backend_present) begin
      tone_live = buzz_on;
      ev_now    = buzz_on ? EV_START : EV_STOP;
    end else begin
      pin_on = buzz_on;
    end
  endfunction

  function automatic void set_buzz(input logic on);
    beep_armed = 1'b0;
    pat_run    = 1'b0;
    buzz_on    = on;
    sound_out();
  endfunction

  function automatic void enter_step();
    step_t s;
    if (pat_pos >= pat_len) begin
      if (!pat_loop) begin
        set_buzz(1'b0);
        return;
      end
      pat_pos = '0;
      n_wraps++;
    end
    s        = step_tab[pat_pos[STORE_AW-1:0]];
    freq_now = (s.freq == '0) ? DEFAULT_FREQ_HZ : s.freq;
    buzz_on  = s.on;
    sound_out();
    step_due = now_ms + TIME_W'(s.dur);
  endfunction

  function automatic res_t predict_status(input cmd_t c);
    res_t             r;
    logic [LEN_W-1:0] len;
    ev_now = EV_NONE;
    case (c.mode)
      MODE_TICK: begin
        now_ms = now_ms + 1;
        if (pat_run && deadline_hit(step_due)) begin
          pat_pos = pat_pos + 1'b1;
          enter_step();
        end
        if (beep_armed && deadline_hit(beep_due)) begin
          beep_armed = 1'b0;
          buzz_on    = 1'b0;
          sound_out();
        end
      end
      MODE_ON:     set_buzz(1'b1);
      MODE_OFF:    set_buzz(1'b0);
      MODE_TOGGLE: set_buzz(!buzz_on);
      MODE_BEEP: begin
        pat_run = 1'b0;
        buzz_on = 1'b1;
        sound_out();
        beep_armed = 1'b1;
        beep_due   = now_ms + TIME_W'(c.length_ms);
      end
      MODE_TONE: begin
        freq_now = (c.tone_hz == '0) ? DEFAULT_FREQ_HZ : c.tone_hz;
        set_buzz(1'b1);
      end
      MODE_PLAY: begin
        len = c.pattern_length;
        if (len != '0) begin
          if (len > MAX_STEPS_L) len = MAX_STEPS_L;
          pat_len    = len;
          pat_pos    = '0;
          pat_loop   = c.repeat_enable;
          pat_run    = 1'b1;
          beep_armed = 1'b0;
          enter_step();
        end
      end
      MODE_LOAD: begin
        step_tab[c.step_index]    = '{on: c.step_on, freq: c.tone_hz, dur: c.length_ms};
        step_loaded[c.step_index] = 1'b1;
      end
    endcase
    r.pin_level      = pin_on ? cfg_m.on_level : !cfg_m.on_level;
    r.tone_event     = ev_now;
    r.tone_running   = tone_live;
    r.tone_freq_hz   = freq_now;
    r.pattern_active = pat_run;
    r.beep_active    = beep_armed;
    if (ev_now == EV_START) n_starts++;
    else if (ev_now == EV_STOP) n_stops++;
    mode_seen[c.mode]++;
    return r;
  endfunction

  function automatic cmd_t mk_cmd(input mode_e m, input logic [IDX_W-1:0] idx,
                                  input logic on, input logic [FREQ_W-1:0] f,
                                  input logic [DUR_W-1:0] d, input logic [LEN_W-1:0] len,
                                  input logic rep);
    cmd_t c;
    c.mode           = m;
    c.step_index     = idx;
    c.step_on        = on;
    c.tone_hz        = f;
    c.length_ms      = d;
    c.pattern_length = len;
    c.repeat_enable  = rep;
    return c;
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return FREQ_W'($urandom);
  endfunction

  // mostly short so beeps and steps actually expire under ticks
  function automatic logic [DUR_W-1:0] pick_dur();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return DUR_W'($urandom_range(0, 3));
    if (r < 13) return DUR_W'($urandom_range(4, 30));
    if (r == 13) return '1;
    return DUR_W'($urandom);
  endfunction

  // number of loaded entries from entry 0 upwards; plays never reach beyond it
  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < MAX_STEPS && step_loaded[n]) n++;
    return n;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    int   pre;
    c    = mk_cmd(MODE_TICK, IDX_W'($urandom), 1'($urandom), pick_freq(), pick_dur(),
                  LEN_W'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    pre  = loaded_prefix();
    if (pick < 45) c.mode = MODE_TICK;
    else if (pick < 55) c.mode = MODE_LOAD;
    else if (pick < 64) begin
      c.mode = MODE_PLAY;
      if (pre == 0) begin
        c.mode       = MODE_LOAD;
        c.step_index = '0;
      end else if (pre == MAX_STEPS && $urandom_range(0, 3) == 0) begin
        c.pattern_length = LEN_W'($urandom_range(MAX_STEPS, 31));
      end else if ($urandom_range(0, 15) == 0) begin
        c.pattern_length = '0;
      end else begin
        c.pattern_length = LEN_W'($urandom_range(1, pre));
      end
    end
    else if (pick < 72) c.mode = MODE_BEEP;
    else if (pick < 79) c.mode = MODE_ON;
    else if (pick < 86) c.mode = MODE_OFF;
    else if (pick < 93) c.mode = MODE_TOGGLE;
    else c.mode = MODE_TONE;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // leaves the beat valid on return, so back-to-back commands need no gap
  task automatic send_cmd(input cmd_t c);
    logic [S_DATA_W-1:0] beat;
    beat = '0;
    beat[42:0] = {c.repeat_enable, c.pattern_length, c.length_ms, c.tone_hz,
                  c.step_on, c.step_index};
    if (src_jitter && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= c.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    status_q.push_back(predict_status(c));
    n_cmds++;
  endtask

  task automatic settle(input int extra);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_config(input logic pas, input logic bk, input logic ah);
    settle(DRAIN_CYCLES);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PASSIVE_MODE;
    cfg_data_i <= pas;
    @(posedge clk_i);
    cfg_m.passive_mode = pas;
    cfg_idx_i  <= CFG_TONE_BACKEND;
    cfg_data_i <= bk;
    @(posedge clk_i);
    cfg_m.tone_backend_present = bk;
    cfg_idx_i  <= CFG_ON_LEVEL;
    cfg_data_i <= ah;
    @(posedge clk_i);
    cfg_m.on_level = ah;
    // out-of-range index must leave every register alone
    cfg_idx_i  <= CFG_IDX_UNUSED;
    cfg_data_i <= 1'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    n_settings++;
  endtask

  task automatic test_directed();
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    send_cmd(mk_cmd(MODE_TICK, '0, 1'b0, '0, '0, '0, 1'b0));
    send_cmd(mk_cmd(MODE_LOAD, 4'd0, 1'b1, '0, '0, '0, 1'b0));
    send_cmd(mk_cmd(MODE_LOAD, 4'd1, 1'b0, '1, 16'd1, '1, 1'b1));
    send_cmd(mk_cmd(MODE_LOAD, 4'd2, 1'b1, 16'd1, 16'd2, '0, 1'b0));
    send_cmd(mk_cmd(MODE_ON, '1, 1'b1, '1, '1, '1, 1'b1));
    send_cmd(mk_cmd(MODE_OFF, '0, 1'b0, '0, '0, '0, 1'b0));
    send_cmd(mk_cmd(MODE_TOGGLE, '0, 1'b0, '0, '0, '0, 1'b0));
    send_cmd(mk_cmd(MODE_TOGGLE, '0, 1'b0, '0, '0, '0, 1'b0));
    // zero frequency falls back to the default tone
    send_cmd(mk_cmd(MODE_TONE, '0, 1'b0, '0, '0, '0, 1'b0));
    send_cmd(mk_cmd(MODE_TONE, '0, 1'b0, '1, '0, '0, 1'b0));
    // zero-length beep ends on the next tick
    send_cmd(mk_cmd(MODE_BEEP, '0, 1'b0, '0, '0, '0, 1'b0));
    send_cmd(mk_cmd(MODE_TICK, '0, 1'b0, '0, '0, '0, 1'b0));
    // longest beep, cut short by a pattern; zero length play is ignored
    send_cmd(mk_cmd(MODE_BEEP, '0, 1'b0, '0, '1, '0, 1'b0));
    send_cmd(mk_cmd(MODE_PLAY, '0, 1'b0, '0, '0, '0, 1'b1));
    send_cmd(mk_cmd(MODE_PLAY, '0, 1'b0, '0, '0, 5'd3, 1'b0));
    repeat (5) send_cmd(mk_cmd(MODE_TICK, '0, 1'b0, '0, '0, '0, 1'b0));
    // repeating pattern wraps, then a new play restarts it mid-step
    send_cmd(mk_cmd(MODE_PLAY, '0, 1'b0, '0, '0, 5'd2, 1'b1));
    repeat (4) send_cmd(mk_cmd(MODE_TICK, '0, 1'b0, '0, '0, '0, 1'b0));
    send_cmd(mk_cmd(MODE_PLAY, '0, 1'b0, '0, '0, 5'd1, 1'b0));
    send_cmd(mk_cmd(MODE_OFF, '0, 1'b0, '0, '0, '0, 1'b0));
  endtask

  // load a short pattern, play it and tick it through, now and then broken up
  task automatic test_patterns(input int n_seq);
    int   n;
    cmd_t c;
    for (int s = 0; s < n_seq; s++) begin
      src_jitter  = ($urandom_range(0, 2) != 0);
      sink_jitter = ($urandom_range(0, 2) != 0);
      n = (s == 0 || $urandom_range(0, 7) == 0) ? MAX_STEPS : $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        send_cmd(mk_cmd(MODE_LOAD, IDX_W'(i), 1'($urandom), pick_freq(),
                        DUR_W'($urandom_range(0, 3)), LEN_W'($urandom), 1'($urandom)));
      c = mk_cmd(MODE_PLAY, IDX_W'($urandom), 1'($urandom), pick_freq(), pick_dur(),
                 LEN_W'(n), 1'($urandom));
      if (n == MAX_STEPS && $urandom_range(0, 1) == 0)
        c.pattern_length = LEN_W'($urandom_range(MAX_STEPS, 31));
      send_cmd(c);
      repeat ($urandom_range(2, 4 * n + 4)) begin
        c = random_cmd();
        if ($urandom_range(0, 19) != 0) c.mode = MODE_TICK;
        send_cmd(c);
      end
    end
  endtask

  task automatic test_config_sweep();
    for (int k = 0; k < 8; k++) begin
      set_config(k[2], k[1], k[0]);
      src_jitter  = ($urandom_range(0, 3) != 0);
      sink_jitter = ($urandom_range(0, 3) != 0);
      repeat (80) send_cmd(random_cmd());
    end
  endtask

  task automatic test_backpressure();
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    hold_left   = HOLD_CYCLES;
    repeat (24) send_cmd(random_cmd());
  endtask

  task automatic test_pause();
    repeat (3) begin
      src_jitter  = 1'b1;
      sink_jitter = 1'b1;
      repeat (12) send_cmd(random_cmd());
      settle(0);
    end
  endtask

  task automatic test_tail();
    set_config(1'b0, 1'b1, 1'b0);
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    repeat (150) send_cmd(random_cmd());
  endtask

  // receiver: long hold-off on request, otherwise short random stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_jitter && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : status_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_status++;
      if (status_q.size() == 0) begin
        report_mismatch("status beat with nothing expected", 32'(m_axis_tdata), '0);
      end else begin
        want = status_q.pop_front();
        if (m_axis_tdata[0] !== want.pin_level)
          report_mismatch("pin_level", 32'(m_axis_tdata[0]), 32'(want.pin_level));
        if (m_axis_tdata[2:1] !== want.tone_event)
          report_mismatch("tone_event", 32'(m_axis_tdata[2:1]), 32'(want.tone_event));
        if (m_axis_tdata[3] !== want.tone_running)
          report_mismatch("tone_running", 32'(m_axis_tdata[3]), 32'(want.tone_running));
        if (m_axis_tdata[19:4] !== want.tone_freq_hz)
          report_mismatch("tone_freq_hz", 32'(m_axis_tdata[19:4]), 32'(want.tone_freq_hz));
        if (m_axis_tdata[20] !== want.pattern_active)
          report_mismatch("pattern_active", 32'(m_axis_tdata[20]), 32'(want.pattern_active));
        if (m_axis_tdata[21] !== want.beep_active)
          report_mismatch("beep_active", 32'(m_axis_tdata[21]), 32'(want.beep_active));
        if (m_axis_tdata[23:22] !== 2'b00)
          report_mismatch("tdata padding", 32'(m_axis_tdata[23:22]), '0);
      end
    end
  end

  // ends the run when neither stream has moved a beat for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_patterns(25);
    test_config_sweep();
    test_patterns(25);
    test_backpressure();
    test_pause();
    test_tail();
    settle(DRAIN_CYCLES);
    $display("run covered %0d commands: %0d ticks, %0d loads, %0d plays, %0d beeps, %0d tones",
             n_cmds, mode_seen[MODE_TICK], mode_seen[MODE_LOAD], mode_seen[MODE_PLAY],
             mode_seen[MODE_BEEP], mode_seen[MODE_TONE]);
    $display("%0d status beats checked, %0d tone starts, %0d stops, %0d wraps, %0d settings",
             n_status, n_starts, n_stops, n_wraps, n_settings);
    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### buzzer_pattern_sequencer_unit.f
sv/bps_pkg.sv
sv/bps_in_stage.sv
sv/bps_core.sv
sv/bps_out_stage.sv
sv/buzzer_pattern_sequencer_unit.sv
tb/sv/tb_buzzer_pattern_sequencer_unit.sv
